// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/fas_pkg.sv
package fas_pkg;

  // Configuration register indexes and reset values
  localparam int unsigned REG_TRIGGER = 0;
  localparam int unsigned REG_REDUCE  = 1;
  localparam logic [31:0] TRIGGER_RESET = 32'd10000;
  localparam logic [31:0] REDUCE_RESET  = 32'd60000;

  // Stop mode codes
  localparam logic [1:0] STOP_NONE    = 2'd0;
  localparam logic [1:0] STOP_MUTED   = 2'd1;
  localparam logic [1:0] STOP_STOPPED = 2'd2;

  // Beeper pattern select codes
  localparam logic [1:0] BEEP_OFF  = 2'd0;
  localparam logic [1:0] BEEP_SLOW = 2'd1;
  localparam logic [1:0] BEEP_FAST = 2'd2;
  localparam logic [1:0] BEEP_STBY = 2'd3;

  // Tick-modulo lanes: period = DIV << SHIFT, beep while remainder < LIMIT
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned LANE_FAST = 0;  // 600 ms period
  localparam int unsigned LANE_SLOW = 1;  // 2000 ms period
  localparam int unsigned LANE_STBY = 2;  // 60000 ms period
  localparam int unsigned REM_W     = 12; // holds up to twice the largest divisor

  localparam int unsigned LANE_SHIFT [NUM_LANES] = '{3, 4, 5};
  localparam logic [31:0] LANE_DIV   [NUM_LANES] = '{32'd75, 32'd125, 32'd1875};
  localparam logic [15:0] LANE_LIMIT [NUM_LANES] = '{16'd300, 16'd1000, 16'd1000};
  // floor(2^32 / DIV): quotient estimate is exact or one short
  localparam logic [31:0] LANE_MAGIC [NUM_LANES] = '{
    32'((64'd1 << 32) / 64'd75),
    32'((64'd1 << 32) / 64'd125),
    32'((64'd1 << 32) / 64'd1875)
  };

endpackage

// File: rtl/fire_alarm_sequencer.sv
// Throughput: one transaction per cycle while the output is not stalled; the sequencer
// state updates at the input register, and the tick-modulo beeper lanes follow in a
// 3-stage pipe. A stalled output halts the whole pipe, and input stall follows it in
// the same cycle.
// Reset (rst_ni low, asynchronous) clears the sequencer state, empties the pipe
// and loads the delay registers with 10000 and 60000 ms.
`include "assert_macros.svh"

module fire_alarm_sequencer
  import fas_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] tick_ms_i,
  input  logic        button_press_i,
  input  logic        fire_detected_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        beeper_on_o,
  output logic        valve_open_o,
  output logic        shutdown_printer_o,
  output logic        standby_o,
  output logic        alarm_running_o
);

  // Configuration registers
  logic [31:0] trigger_q, reduce_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? reduce_q : trigger_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q <= TRIGGER_RESET;
      reduce_q  <= REDUCE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == 1'(REG_REDUCE)) begin
        reduce_q <= pwdata;
      end else begin
        trigger_q <= pwdata;
      end
    end
  end

  // Pipe advance: everything moves unless a held result is stalled
  logic adv;
  logic v1_q, v2_q, v3_q, vo_q;

  assign adv        = !(vo_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // Stage 1: input register
  logic [31:0] tick1_q;
  logic        press1_q, fire1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tick1_q  <= tick_ms_i;
      press1_q <= button_press_i;
      fire1_q  <= fire_detected_i;
    end
  end

  // Sequencer state
  logic [1:0]  stop_q, stop_d;
  logic        run_q, run_d;
  logic [31:0] start_q, start_d;
  logic        valve_q, valve_d;
  logic [31:0] vtime_q, vtime_d;
  logic        stby_q, stby_d;
  logic        ben_q, ben_d;
  logic        pulse_d;
  logic [1:0]  sel_d;
  logic [31:0] trig_sum, red_base, red_sum;
  logic        trig_hit, red_hit;

  // Delay compares; the standby base is the open time, or this tick if opening now
  assign trig_sum = start_q + trigger_q;
  assign trig_hit = tick1_q > trig_sum;
  assign red_base = valve_q ? vtime_q : tick1_q;
  assign red_sum  = red_base + reduce_q;
  assign red_hit  = tick1_q > red_sum;

  // Beeper pattern from the state before this update
  always_comb begin
    if (!ben_q) begin
      sel_d = BEEP_OFF;
    end else if (run_q && !valve_q) begin
      sel_d = BEEP_SLOW;
    end else if (!stby_q) begin
      sel_d = BEEP_FAST;
    end else begin
      sel_d = BEEP_STBY;
    end
  end

  // Next state
  always_comb begin
    stop_d  = stop_q;
    run_d   = run_q;
    start_d = start_q;
    valve_d = valve_q;
    vtime_d = vtime_q;
    stby_d  = stby_q;
    ben_d   = ben_q;
    pulse_d = 1'b0;
    if (stop_q == STOP_STOPPED) begin
      // only a press re-arms; nothing starts in this update
      if (press1_q) begin
        stop_d = STOP_NONE;
      end
    end else if (!run_q) begin
      if ((press1_q || fire1_q) && stop_q == STOP_NONE) begin
        run_d   = 1'b1;
        start_d = tick1_q;
        ben_d   = 1'b1;
      end
    end else if (press1_q && stop_q != STOP_NONE) begin
      // second press stops the sequence, standby kept
      run_d   = 1'b0;
      start_d = '0;
      vtime_d = '0;
      valve_d = 1'b0;
      ben_d   = 1'b0;
      stop_d  = STOP_STOPPED;
    end else begin
      if (press1_q) begin
        ben_d  = 1'b0;
        stop_d = STOP_MUTED;
      end
      if (trig_hit) begin
        ben_d = 1'b1;
        if (!valve_q) begin
          vtime_d = tick1_q;
          valve_d = 1'b1;
          pulse_d = 1'b1;
        end
      end
      if ((valve_q || trig_hit) && red_hit) begin
        stby_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q  <= STOP_NONE;
      run_q   <= 1'b0;
      start_q <= '0;
      valve_q <= 1'b0;
      vtime_q <= '0;
      stby_q  <= 1'b0;
      ben_q   <= 1'b0;
    end else if (v1_q && adv) begin
      stop_q  <= stop_d;
      run_q   <= run_d;
      start_q <= start_d;
      valve_q <= valve_d;
      vtime_q <= vtime_d;
      stby_q  <= stby_d;
      ben_q   <= ben_d;
    end
  end

  // Stage 2 / 3 side payload: pattern select and flags
  logic [1:0]  sel2_q, sel3_q;
  logic [3:0]  flg2_q, flg3_q;   // valve, pulse, standby, running
  logic [31:0] tick2_q;
  logic [4:0]  low3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel2_q  <= sel_d;
      flg2_q  <= {valve_d, pulse_d, stby_d, run_d};
      tick2_q <= tick1_q;
      sel3_q  <= sel2_q;
      flg3_q  <= flg2_q;
      low3_q  <= tick2_q[4:0];
    end
  end

  // Modulo lanes: reciprocal multiply, back-multiply, one correction step
  logic [31:0]      q2_q    [NUM_LANES];
  logic [REM_W-1:0] rest3_q [NUM_LANES];
  logic [NUM_LANES-1:0] hit;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [31:0]      x1, x2, qc;
    logic [63:0]      prod;
    logic [REM_W-1:0] r;
    logic [15:0]      rem, low_mask;

    // stage 1: quotient estimate
    assign x1   = tick1_q >> LANE_SHIFT[l];
    assign prod = x1 * LANE_MAGIC[l];

    // stage 2: remainder estimate, below twice the divisor
    assign x2 = tick2_q >> LANE_SHIFT[l];
    assign qc = 32'(q2_q[l] * LANE_DIV[l]);

    // stage 3: correct and rebuild the full remainder
    assign r        = (rest3_q[l] >= REM_W'(LANE_DIV[l])) ?
                      REM_W'(rest3_q[l] - REM_W'(LANE_DIV[l])) : rest3_q[l];
    assign low_mask = 16'((32'd1 << LANE_SHIFT[l]) - 32'd1);
    assign rem      = 16'(16'(r) << LANE_SHIFT[l]) | (16'(low3_q) & low_mask);
    assign hit[l]   = rem < LANE_LIMIT[l];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        q2_q[l]    <= prod[63:32];
        rest3_q[l] <= REM_W'(x2 - qc);
      end
    end
  end

  // Output register
  logic beep_d;

  always_comb begin
    case (sel3_q)
      BEEP_OFF:  beep_d = 1'b0;
      BEEP_SLOW: beep_d = hit[LANE_SLOW];
      BEEP_FAST: beep_d = hit[LANE_FAST];
      BEEP_STBY: beep_d = hit[LANE_STBY];
      default:   beep_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      beeper_on_o        <= beep_d;
      valve_open_o       <= flg3_q[3];
      shutdown_printer_o <= flg3_q[2];
      standby_o          <= flg3_q[1];
      alarm_running_o    <= flg3_q[0];
    end
  end

  assign out_valid_o = vo_q;

  // Checks
  `ASSERT_IMPLIES(a_valve_needs_run, clk_i, rst_ni, valve_q, run_q)
  `ASSERT_IMPLIES(a_stopped_idle, clk_i, rst_ni, stop_q == STOP_STOPPED, !run_q && !valve_q)
  `ASSERT_NEXT(a_standby_sticky, clk_i, rst_ni, stby_q, stby_q)
  `ASSERT_IMPLIES(a_pulse_with_valve, clk_i, rst_ni, vo_q && shutdown_printer_o, valve_open_o)

endmodule

// File: verif/fire_alarm_sequencer_test.sv
module fire_alarm_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fas_pkg::*;

  // One result transaction, in port order
  typedef struct packed {
    logic beeper_on;
    logic valve_open;
    logic shutdown_printer;
    logic standby;
    logic alarm_running;
  } alarm_outputs_t;

  // Sequencer prediction and the queue of outputs still owed by the block
  class alarm_scoreboard;
    logic [31:0]    trigger_delay;
    logic [31:0]    reduce_delay;
    logic [1:0]     stop_mode;
    bit             running;
    logic [31:0]    start_ms;
    bit             valve;
    logic [31:0]    valve_ms;
    bit             standby_set;
    bit             beep_en;
    alarm_outputs_t pending_outputs[$];
    int unsigned    mismatches;

    function new();
      trigger_delay = TRIGGER_RESET;
      reduce_delay  = REDUCE_RESET;
      stop_mode     = STOP_NONE;
      running       = 1'b0;
      start_ms      = '0;
      valve         = 1'b0;
      valve_ms      = '0;
      standby_set   = 1'b0;
      beep_en       = 1'b0;
      mismatches    = 0;
    endfunction

    function void write_register(int unsigned index, logic [31:0] value);
      case (index)
        REG_TRIGGER: trigger_delay = value;
        REG_REDUCE:  reduce_delay  = value;
        default: ;
      endcase
    endfunction

    // Beeper level from the state held before the update
    function bit beep_level(logic [31:0] tick);
      if (!beep_en) return 1'b0;
      if (running && !valve) return (tick % 32'd2000) < 32'd1000;
      if (!standby_set) return (tick % 32'd600) < 32'd300;
      return (tick % 32'd60000) < 32'd1000;
    endfunction

    function void note_update(logic [31:0] tick, bit press, bit fire);
      alarm_outputs_t expected;
      logic [31:0]    trigger_at;
      logic [31:0]    standby_at;
      bit             halted;
      expected = '0;
      expected.beeper_on = beep_level(tick);
      halted = 1'b0;
      if (stop_mode == STOP_STOPPED) begin
        // stopped: fire ignored, a press only re-arms
        if (press) stop_mode = STOP_NONE;
      end else if (!running) begin
        if ((press || fire) && stop_mode == STOP_NONE) begin
          running  = 1'b1;
          start_ms = tick;
          beep_en  = 1'b1;
        end
      end else begin
        if (press) begin
          if (stop_mode == STOP_NONE) begin
            beep_en   = 1'b0;
            stop_mode = STOP_MUTED;
          end else begin
            running   = 1'b0;
            start_ms  = '0;
            valve_ms  = '0;
            valve     = 1'b0;
            beep_en   = 1'b0;
            stop_mode = STOP_STOPPED;
            halted    = 1'b1;
          end
        end
        if (!halted) begin
          // sums wrap at 32 bits, compares unsigned
          trigger_at = start_ms + trigger_delay;
          if (tick > trigger_at) begin
            beep_en = 1'b1;
            if (!valve) begin
              valve_ms = tick;
              valve    = 1'b1;
              expected.shutdown_printer = 1'b1;
            end
          end
          standby_at = valve_ms + reduce_delay;
          if (valve && tick > standby_at) standby_set = 1'b1;
        end
      end
      expected.valve_open    = valve;
      expected.standby       = standby_set;
      expected.alarm_running = running;
      pending_outputs.push_back(expected);
    endfunction

    function void compare_bit(string field, logic want, logic seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_outputs(alarm_outputs_t seen);
      alarm_outputs_t want;
      if (pending_outputs.size() == 0) begin
        $error("output transaction with none outstanding");
        mismatches++;
        return;
      end
      want = pending_outputs.pop_front();
      compare_bit("beeper_on", want.beeper_on, seen.beeper_on);
      compare_bit("valve_open", want.valve_open, seen.valve_open);
      compare_bit("shutdown_printer", want.shutdown_printer, seen.shutdown_printer);
      compare_bit("standby", want.standby, seen.standby);
      compare_bit("alarm_running", want.alarm_running, seen.alarm_running);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] tick_ms_i = '0;
  logic        button_press_i = 1'b0;
  logic        fire_detected_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        beeper_on_o;
  logic        valve_open_o;
  logic        shutdown_printer_o;
  logic        standby_o;
  logic        alarm_running_o;

  alarm_scoreboard board = new();
  bit              quiet_phase = 1'b0;
  logic [31:0]     clock_ms;

  fire_alarm_sequencer dut (.*);

  always #5ns clk_i = ~clk_i;

  // Mostly short gaps, the odd long one
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sink side stall pattern
  initial begin
    int unsigned hold;
    forever begin
      repeat ($urandom_range(1, 12)) @(negedge clk_i) out_stall_i <= 1'b0;
      hold = quiet_phase ? 0 : idle_length();
      repeat (hold) @(negedge clk_i) out_stall_i <= 1'b1;
    end
  end

  // Check every accepted output transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_outputs(alarm_outputs_t'({beeper_on_o, valve_open_o, shutdown_printer_o,
                                            standby_o, alarm_running_o}));
  end

  task automatic send_update(input logic [31:0] tick, input bit press, input bit fire);
    int unsigned gap;
    gap = quiet_phase ? 0 : idle_length();
    if (gap != 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    tick_ms_i       <= tick;
    button_press_i  <= press;
    fire_detected_i <= fire;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_update(tick, press, fire);
  endtask

  task automatic drain_outputs();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (board.pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input int unsigned index, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(index * 4);
    pwdata  <= value;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.write_register(index, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reconfigure while idle, then a run of updates, mostly with an advancing tick
  task automatic run_phase(input logic [31:0] trigger, input logic [31:0] reduce,
                           input int unsigned step_cap, input int unsigned count,
                           input bit quiet);
    int unsigned roll;
    logic [31:0] tick;
    bit          press;
    bit          fire;
    drain_outputs();
    write_register(REG_TRIGGER, trigger);
    write_register(REG_REDUCE, reduce);
    quiet_phase = quiet;
    if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    else clock_ms = $urandom_range(0, 1 << 20);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any tick, any flags
        tick  = $urandom();
        press = 1'($urandom_range(0, 1));
        fire  = 1'($urandom_range(0, 1));
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_cap);
        tick  = clock_ms;
        press = $urandom_range(0, 99) < 6;
        fire  = $urandom_range(0, 99) < 12;
      end
      send_update(tick, press, fire);
    end
    quiet_phase = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: idle, slow beep, mute, valve opening, stop and re-arm, wrap
    send_update(32'd0, 1'b0, 1'b0);
    send_update(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_update(32'd1000, 1'b0, 1'b1);
    send_update(32'd1500, 1'b0, 1'b0);
    send_update(32'd2100, 1'b0, 1'b0);
    send_update(32'd3000, 1'b1, 1'b0);
    send_update(32'd3999, 1'b0, 1'b0);
    send_update(32'd11000, 1'b0, 1'b0);
    send_update(32'd11001, 1'b0, 1'b0);
    send_update(32'd11002, 1'b0, 1'b0);
    send_update(32'd11400, 1'b0, 1'b0);
    send_update(32'd11650, 1'b1, 1'b1);
    send_update(32'd12000, 1'b0, 1'b1);
    send_update(32'd12100, 1'b1, 1'b0);
    send_update(32'd12200, 1'b1, 1'b0);
    send_update(32'd12300, 1'b1, 1'b0);
    send_update(32'd12400, 1'b1, 1'b0);
    send_update(32'd12500, 1'b1, 1'b1);
    send_update(32'hFFFF_FFF0, 1'b0, 1'b1);
    send_update(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_update(32'd5, 1'b0, 1'b0);
    send_update(32'd4, 1'b1, 1'b1);
    send_update(32'd0, 1'b1, 1'b0);

    // Random phases over several delay settings, extremes included
    run_phase(32'd2000, 32'd500000, 300, 300, 1'b0);
    run_phase(32'd0, 32'd0, 50, 250, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1000, 250, 1'b1);
    run_phase($urandom_range(0, 5000), $urandom_range(0, 5000), 400, 250, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'd0, 200, 250, 1'b0);
    run_phase(32'd0, 32'hFFFF_FFFF, 200, 250, 1'b0);
    run_phase(TRIGGER_RESET, REDUCE_RESET, 3000, 250, 1'b0);
    run_phase($urandom(), $urandom(), 1 << 30, 200, 1'b0);

    drain_outputs();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_outputs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
